### rtl/serial_to_spi_command_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// serial to spi command parser assertion macros
// concurrent check helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef SERIAL_TO_SPI_COMMAND_PARSER_UNIT_DEFINES_SVH
`define SERIAL_TO_SPI_COMMAND_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds in the same cycle
`define S2SPI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s2spi check failed");
// condition holds in the next cycle
`define S2SPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s2spi check failed");
`else
`define S2SPI_ASSERT_NOW(label, ante, cons)
`define S2SPI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/s2spi_pkg.sv
// ----------------------------------------------------------------------------
// s2spi_pkg
// shared constants, types and helpers of the serial to spi command parser
// ----------------------------------------------------------------------------
package s2spi_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [7:0] CHAR_THREE = 8'h33;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] ALPHA_OFS  = 8'h37;

    // result kind codes
    localparam logic [1:0] RK_CS   = 2'd0;
    localparam logic [1:0] RK_MODE = 2'd1;
    localparam logic [1:0] RK_TX   = 2'd2;
    localparam logic [1:0] RK_HEX  = 2'd3;

    // source of the next output word
    typedef enum logic [2:0] {
        SEL_CS,
        SEL_MODE,
        SEL_HEX_HI,
        SEL_HEX_LO,
        SEL_TX
    } out_sel_t;

    typedef struct packed {
        logic       out_load;
        out_sel_t   out_sel;
        logic [1:0] out_arg;
        logic       hex_capture;
        logic       digit_hi_wr;
        logic       pair_wr;
        logic       rd_start;
        logic       rd_next;
        logic       burst_end;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic cnt_zero;
        logic rd_last;
    } status_t;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                d = c - CHAR_ZERO;
            end
            else if (c >= CHAR_A && c <= CHAR_F)
            begin
                d = c - ALPHA_OFS;
            end
            return d[3:0];
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        begin
            return (n <= 4'd9) ? ({4'h0, n} + CHAR_ZERO) : ({4'h0, n} + ALPHA_OFS);
        end
    endfunction

endpackage

### rtl/serial_to_spi_command_parser_unit.sv
// ----------------------------------------------------------------------------
// serial_to_spi_command_parser_unit
// cs, mode and hex words are registered in the output word register; transmit bytes
// pass the ram read register first. 1 word per cycle with a free output; spi bytes
// and data newlines hold input until their last word, 1 byte per cycle to a free output
// reset: asynchronous, parser idle, byte count and overflow flag cleared
// ----------------------------------------------------------------------------
`include "serial_to_spi_command_parser_unit_defines.svh"

module serial_to_spi_command_parser_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] value,
    output logic       last,
    output logic       dropped
);
    import s2spi_pkg::*;

    // controller to datapath commands and returned status
    cmd_t    cmd;
    status_t status;

    // the controller owns the text parser and the output sequencer;
    // it accepts a word only when the output register can take a result,
    // so a waiting result also holds back words that produce nothing
    s2spi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .data     (data),
        .status   (status),
        .cmd      (cmd)
    );

    // the datapath holds the transmit buffer ram, the byte counter,
    // the overflow flag and the output word register
    s2spi_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data        (data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .value       (value),
        .last        (last),
        .dropped     (dropped)
    );

    // the output register is never overwritten while holding a word
    `S2SPI_ASSERT_NOW(a_no_overwrite, cmd.out_load, status.out_free)
    // input is taken only when the output can absorb a result
    `S2SPI_ASSERT_NOW(a_ready_free, in_ready, !out_valid || out_ready)
    // an spi byte yields a first hex word that is not last
    `S2SPI_ASSERT_NEXT(a_hex_first, in_valid && in_ready && kind,
        out_valid && (result_kind == RK_HEX) && !last)
    // dropped only marks transmit bytes
    `S2SPI_ASSERT_NOW(a_dropped_tx, out_valid && dropped, result_kind == RK_TX)

endmodule

### rtl/s2spi_ram.sv
// ----------------------------------------------------------------------------
// s2spi_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module s2spi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/s2spi_ctrl.sv
// ----------------------------------------------------------------------------
// s2spi_ctrl
// command parser state machine and output sequencer
// ----------------------------------------------------------------------------
module s2spi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [7:0]          data,
    input  s2spi_pkg::status_t  status,
    output s2spi_pkg::cmd_t     cmd
);
    import s2spi_pkg::*;

    typedef enum logic [11:0] {
        P_IDLE = 12'b0000_0000_0001,
        P_C    = 12'b0000_0000_0010,
        P_CS   = 12'b0000_0000_0100,
        P_CS0  = 12'b0000_0000_1000,
        P_CS1  = 12'b0000_0001_0000,
        P_M    = 12'b0000_0010_0000,
        P_M0   = 12'b0000_0100_0000,
        P_M1   = 12'b0000_1000_0000,
        P_M2   = 12'b0001_0000_0000,
        P_M3   = 12'b0010_0000_0000,
        P_D1   = 12'b0100_0000_0000,
        P_D2   = 12'b1000_0000_0000
    } parse_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_HEX_LO = 3'b010,
        S_BURST  = 3'b100
    } seq_t;

    parse_t parse_reg, parse_next;
    seq_t   seq_reg, seq_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg <= P_IDLE;
            seq_reg   <= S_IDLE;
        end
        else
        begin
            parse_reg <= parse_next;
            seq_reg   <= seq_next;
        end
    end

    assign in_ready = (seq_reg == S_IDLE) && status.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        parse_next = parse_reg;
        seq_next   = seq_reg;
        cmd        = '0;
        cmd.out_sel = SEL_CS;

        unique case (seq_reg)
            S_IDLE:
            begin
                if (accept && kind)
                begin
                    // spi byte back: high nibble now, low nibble next
                    cmd.out_load    = 1'b1;
                    cmd.out_sel     = SEL_HEX_HI;
                    cmd.hex_capture = 1'b1;
                    seq_next        = S_HEX_LO;
                end
                else if (accept)
                begin
                    parse_next = P_IDLE;
                    unique case (parse_reg)
                        P_IDLE:
                        begin
                            if (data == CHAR_D)
                            begin
                                parse_next = P_D1;
                            end
                            else if (data == CHAR_C)
                            begin
                                parse_next = P_C;
                            end
                            else if (data == CHAR_M)
                            begin
                                parse_next = P_M;
                            end
                        end
                        P_C:
                        begin
                            if (data == CHAR_S)
                            begin
                                parse_next = P_CS;
                            end
                        end
                        P_CS:
                        begin
                            if (data == CHAR_ZERO)
                            begin
                                parse_next = P_CS0;
                            end
                            else if (data == CHAR_ONE)
                            begin
                                parse_next = P_CS1;
                            end
                        end
                        P_CS0, P_CS1:
                        begin
                            if (data == CHAR_NL)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = SEL_CS;
                                cmd.out_arg  = (parse_reg == P_CS1) ? 2'd1 : 2'd0;
                            end
                        end
                        P_M:
                        begin
                            case (data)
                                CHAR_ZERO:  parse_next = P_M0;
                                CHAR_ONE:   parse_next = P_M1;
                                CHAR_TWO:   parse_next = P_M2;
                                CHAR_THREE: parse_next = P_M3;
                                default:    parse_next = P_IDLE;
                            endcase
                        end
                        P_M0, P_M1, P_M2, P_M3:
                        begin
                            if (data == CHAR_NL)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = SEL_MODE;
                                cmd.out_arg  = {(parse_reg == P_M2) || (parse_reg == P_M3),
                                                (parse_reg == P_M1) || (parse_reg == P_M3)};
                            end
                        end
                        P_D1:
                        begin
                            if (data == CHAR_NL)
                            begin
                                if (!status.cnt_zero)
                                begin
                                    cmd.rd_start = 1'b1;
                                    seq_next     = S_BURST;
                                end
                            end
                            else
                            begin
                                cmd.digit_hi_wr = 1'b1;
                                parse_next      = P_D2;
                            end
                        end
                        P_D2:
                        begin
                            cmd.pair_wr = 1'b1;
                            parse_next  = P_D1;
                        end
                        default:
                        begin
                            parse_next = P_IDLE;
                        end
                    endcase
                end
            end
            S_HEX_LO:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_HEX_LO;
                    seq_next     = S_IDLE;
                end
            end
            S_BURST:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_TX;
                    if (status.rd_last)
                    begin
                        cmd.burst_end = 1'b1;
                        seq_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                seq_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/s2spi_dp.sv
// ----------------------------------------------------------------------------
// s2spi_dp
// transmit buffer, byte counter, digit latches and output word register
// ----------------------------------------------------------------------------
module s2spi_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data,
    input  s2spi_pkg::cmd_t     cmd,
    output s2spi_pkg::status_t  status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          result_kind,
    output logic [7:0]          value,
    output logic                last,
    output logic                dropped
);
    import s2spi_pkg::*;

    logic [3:0]        high_digit_reg;
    logic [3:0]        hex_lo_reg;
    logic [CNT_W-1:0]  byte_count_reg;
    logic              overflow_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [7:0]        out_value_reg;
    logic              out_last_reg;
    logic              out_dropped_reg;

    logic              buf_full;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic [1:0]        kind_next;
    logic [7:0]        value_next;
    logic              last_next;
    logic              dropped_next;

    assign buf_full = (byte_count_reg == CNT_W'(BUFFER_DEPTH));
    assign ram_we   = cmd.pair_wr && !buf_full;
    assign ram_re   = cmd.rd_start || cmd.rd_next;
    assign ram_raddr = cmd.rd_start ? '0 : (rd_idx_reg + ADDR_W'(1));

    s2spi_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (byte_count_reg[ADDR_W-1:0]),
        .wdata ({high_digit_reg, nibble_of(data)}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.out_free = !out_valid_reg || out_ready;
    assign status.cnt_zero = (byte_count_reg == '0);
    assign status.rd_last  = (CNT_W'(rd_idx_reg) == (byte_count_reg - CNT_W'(1)));

    always_comb
    begin
        kind_next    = RK_CS;
        value_next   = 8'h00;
        last_next    = 1'b1;
        dropped_next = 1'b0;
        unique case (cmd.out_sel)
            SEL_CS:
            begin
                kind_next  = RK_CS;
                value_next = {6'd0, cmd.out_arg};
            end
            SEL_MODE:
            begin
                kind_next  = RK_MODE;
                value_next = {6'd0, cmd.out_arg};
            end
            SEL_HEX_HI:
            begin
                kind_next  = RK_HEX;
                value_next = hex_char(data[7:4]);
                last_next  = 1'b0;
            end
            SEL_HEX_LO:
            begin
                kind_next  = RK_HEX;
                value_next = hex_char(hex_lo_reg);
            end
            SEL_TX:
            begin
                kind_next    = RK_TX;
                value_next   = ram_rdata;
                last_next    = status.rd_last;
                dropped_next = overflow_reg;
            end
            default:
            begin
                kind_next = RK_CS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            overflow_reg   <= 1'b0;
            high_digit_reg <= 4'h0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.digit_hi_wr)
            begin
                high_digit_reg <= nibble_of(data);
            end
            if (cmd.burst_end)
            begin
                byte_count_reg <= '0;
                overflow_reg   <= 1'b0;
            end
            else if (cmd.pair_wr)
            begin
                if (buf_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    byte_count_reg <= byte_count_reg + CNT_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.hex_capture)
        begin
            hex_lo_reg <= data[3:0];
        end
        if (ram_re)
        begin
            rd_idx_reg <= ram_raddr;
        end
        if (cmd.out_load)
        begin
            out_kind_reg    <= kind_next;
            out_value_reg   <= value_next;
            out_last_reg    <= last_next;
            out_dropped_reg <= dropped_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign value       = out_value_reg;
    assign last        = out_last_reg;
    assign dropped     = out_dropped_reg;

endmodule

### tb/sv/serial_to_spi_command_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// serial_to_spi_command_parser_unit_tb
// drives serial characters and returned spi bytes into the parser, predicts
// every chip-select, mode, transmit and hex result word in step, and checks
// the words that come out in order, under random sender gaps and receiver
// stalls
// ----------------------------------------------------------------------------
module serial_to_spi_command_parser_unit_tb;

    import s2spi_pkg::*;

    // nothing accepted on either side for this many cycles ends the run
    localparam int QUIET_LIMIT   = 2000;
    // a result word comes registered after its cause, give it some margin
    localparam int SETTLE_CYCLES = 16;
    // random words that the parser does not simply ignore
    localparam int RANDOM_WORDS  = 240;
    localparam int REPORT_MAX    = 10;

    // one result word as it appears on the output side
    typedef struct packed {
        logic [1:0] rkind;
        logic [7:0] val;
        logic       is_last;
        logic       lost;
    } result_t;

    // one line of the directed table; n_typed < 0 means the predictor decides
    typedef struct {
        logic       k;
        logic [7:0] c;
        int         n_typed;
        result_t    r0;
        result_t    r1;
    } stim_row_t;

    // parser position inside a command
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GOT_C,
        ST_GOT_CS,
        ST_CS_LEVEL,
        ST_GOT_M,
        ST_MODE_SET,
        ST_DATA_HI,
        ST_DATA_LO
    } parse_st_t;

    // receiver stall styles
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_THIRD,
        RX_COIN,
        RX_BLOCKS
    } rx_style_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic       kind      = 1'b0;
    logic [7:0] data      = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] result_kind;
    logic [7:0] value;
    logic       last;
    logic       dropped;

    // parser state as the predictor sees it
    parse_st_t  parser_st   = ST_IDLE;
    logic       pend_level  = 1'b0;
    logic [1:0] pend_mode   = 2'd0;
    logic [3:0] hi_nib      = 4'd0;
    logic [7:0] tx_bytes [BUFFER_DEPTH];
    int         n_bytes     = 0;
    logic       pairs_lost  = 1'b0;

    // words produced by the last parser step, and all words still owed by the dut
    result_t    step_out[$];
    result_t    parser_results[$];
    stim_row_t  directed_rows[$];

    int         fail_count   = 0;
    int         result_index = 0;
    int         work_words   = 0;
    int         burst_left   = 0;
    int         quiet_cycles = 0;

    serial_to_spi_command_parser_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .data        (data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .value       (value),
        .last        (last),
        .dropped     (dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // hex digit value, anything that is not 0-9 or A-F counts as zero
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                d = c - CHAR_ZERO;
            end
            else if (c >= CHAR_A && c <= CHAR_F)
            begin
                d = c - CHAR_A + 8'd10;
            end
            return d[3:0];
        end
    endfunction

    // uppercase ascii of one nibble
    function automatic logic [7:0] ascii_hex(input logic [3:0] n);
        begin
            return (n <= 4'd9) ? (CHAR_ZERO + {4'h0, n}) : (ALPHA_OFS + {4'h0, n});
        end
    endfunction

    function automatic result_t mk_result(input logic [1:0] rk, input logic [7:0] v,
                                          input logic lst, input logic drp);
        result_t r;
        begin
            r.rkind   = rk;
            r.val     = v;
            r.is_last = lst;
            r.lost    = drp;
            return r;
        end
    endfunction

    // one accepted word through the parser; results land in step_out
    task automatic run_parser(input logic k, input logic [7:0] c, output bit ignored);
        int i;
        begin
            step_out.delete();
            ignored = 1'b0;
            if (k)
            begin
                // spi byte back: two hex characters, parser state untouched
                step_out.push_back(mk_result(RK_HEX, ascii_hex(c[7:4]), 1'b0, 1'b0));
                step_out.push_back(mk_result(RK_HEX, ascii_hex(c[3:0]), 1'b1, 1'b0));
                return;
            end
            case (parser_st)
                ST_IDLE:
                begin
                    if (c == CHAR_D)
                    begin
                        parser_st = ST_DATA_HI;
                    end
                    else if (c == CHAR_C)
                    begin
                        parser_st = ST_GOT_C;
                    end
                    else if (c == CHAR_M)
                    begin
                        parser_st = ST_GOT_M;
                    end
                    else
                    begin
                        ignored = 1'b1;
                    end
                end
                ST_GOT_C:
                begin
                    parser_st = (c == CHAR_S) ? ST_GOT_CS : ST_IDLE;
                end
                ST_GOT_CS:
                begin
                    if (c == CHAR_ZERO || c == CHAR_ONE)
                    begin
                        pend_level = c[0];
                        parser_st  = ST_CS_LEVEL;
                    end
                    else
                    begin
                        parser_st = ST_IDLE;
                    end
                end
                ST_CS_LEVEL:
                begin
                    if (c == CHAR_NL)
                    begin
                        step_out.push_back(mk_result(RK_CS, {7'd0, pend_level}, 1'b1, 1'b0));
                    end
                    parser_st = ST_IDLE;
                end
                ST_GOT_M:
                begin
                    if (c >= CHAR_ZERO && c <= CHAR_THREE)
                    begin
                        pend_mode = c[1:0];
                        parser_st = ST_MODE_SET;
                    end
                    else
                    begin
                        parser_st = ST_IDLE;
                    end
                end
                ST_MODE_SET:
                begin
                    if (c == CHAR_NL)
                    begin
                        step_out.push_back(mk_result(RK_MODE, {6'd0, pend_mode}, 1'b1, 1'b0));
                    end
                    parser_st = ST_IDLE;
                end
                ST_DATA_HI:
                begin
                    if (c == CHAR_NL)
                    begin
                        for (i = 0; i < n_bytes; i++)
                        begin
                            step_out.push_back(mk_result(RK_TX, tx_bytes[i],
                                                         (i == n_bytes - 1), pairs_lost));
                        end
                        n_bytes    = 0;
                        pairs_lost = 1'b0;
                        parser_st  = ST_IDLE;
                    end
                    else
                    begin
                        hi_nib    = digit_value(c);
                        parser_st = ST_DATA_LO;
                    end
                end
                ST_DATA_LO:
                begin
                    if (n_bytes < BUFFER_DEPTH)
                    begin
                        tx_bytes[n_bytes] = {hi_nib, digit_value(c)};
                        n_bytes++;
                    end
                    else
                    begin
                        pairs_lost = 1'b1;
                    end
                    parser_st = ST_DATA_HI;
                end
                default:
                begin
                    parser_st = ST_IDLE;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // present one word, wait for the handshake, then book what it should cause
    task automatic send_word(input logic k, input logic [7:0] c, input int n_typed,
                             input result_t t0, input result_t t1);
        int  gap;
        bit  skipped;
        begin
            // bursts of words separated by idle gaps, now and then a long stretch
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 12);
                repeat (gap)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                end
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 8);
            end
            @(negedge clk);
            in_valid <= 1'b1;
            kind     <= k;
            data     <= c;
            do
            begin
                @(posedge clk);
            end
            while (in_ready !== 1'b1);
            burst_left--;

            run_parser(k, c, skipped);
            if (n_typed < 0)
            begin
                foreach (step_out[i])
                begin
                    parser_results.push_back(step_out[i]);
                end
            end
            else
            begin
                // hand-typed rows stand in for the predictor's words
                if (n_typed >= 1)
                begin
                    parser_results.push_back(t0);
                end
                if (n_typed >= 2)
                begin
                    parser_results.push_back(t1);
                end
            end
            if (!skipped)
            begin
                work_words++;
            end
        end
    endtask

    // serial character, sometimes preceded by a byte coming back from spi
    task automatic send_char(input logic [7:0] c);
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_word(1'b1, 8'($urandom_range(0, 255)), -1, '0, '0);
            end
            send_word(1'b0, c, -1, '0, '0);
        end
    endtask

    // newlines close whatever command is open, at most two are needed
    task automatic flush_parser();
        begin
            while (parser_st != ST_IDLE)
            begin
                send_char(CHAR_NL);
            end
        end
    endtask

    // sender holds off until the dut has delivered everything owed
    task automatic drain_outputs();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (parser_results.size() != 0)
            begin
                @(posedge clk);
            end
        end
    endtask

    // data digit: mostly real hex, some lowercase that counts as zero, and raw bytes
    function automatic logic [7:0] pick_digit(input bit may_be_nl);
        int         p;
        logic [7:0] b;
        begin
            p = $urandom_range(0, 99);
            if (p < 70)
            begin
                return ascii_hex(4'($urandom_range(0, 15)));
            end
            if (p < 82)
            begin
                return 8'("a") + 8'($urandom_range(0, 5));
            end
            if (may_be_nl && p < 88)
            begin
                return CHAR_NL;
            end
            b = 8'($urandom_range(0, 255));
            if (!may_be_nl && b == CHAR_NL)
            begin
                b = 8'h00;
            end
            return b;
        end
    endfunction

    task automatic send_data_cmd(input int pairs, input bit odd);
        int i;
        begin
            flush_parser();
            send_char(CHAR_D);
            for (i = 0; i < pairs; i++)
            begin
                send_char(pick_digit(1'b0));
                send_char(pick_digit(1'b1));
            end
            // a lone digit takes the first newline as its low digit
            if (odd)
            begin
                send_char(pick_digit(1'b0));
                send_char(CHAR_NL);
            end
            send_char(CHAR_NL);
        end
    endtask

    // command followed by a random character where the next one belongs
    task automatic send_broken_cmd();
        begin
            flush_parser();
            case ($urandom_range(0, 4))
                0:
                begin
                    send_char(CHAR_C);
                end
                1:
                begin
                    send_char(CHAR_C);
                    send_char(CHAR_S);
                end
                2:
                begin
                    send_char(CHAR_C);
                    send_char(CHAR_S);
                    send_char(CHAR_ZERO + 8'($urandom_range(0, 1)));
                end
                3:
                begin
                    send_char(CHAR_M);
                end
                default:
                begin
                    send_char(CHAR_M);
                    send_char(CHAR_ZERO + 8'($urandom_range(0, 3)));
                end
            endcase
            send_char(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic add_row(input logic k, input logic [7:0] c, input int n_typed,
                           input result_t r0, input result_t r1);
        stim_row_t row;
        begin
            row.k       = k;
            row.c       = c;
            row.n_typed = n_typed;
            row.r0      = r0;
            row.r1      = r1;
            directed_rows.push_back(row);
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver stalls: a style is held for a while, then another is drawn
    // ------------------------------------------------------------------------
    initial
    begin
        rx_style_t style;
        int        style_left;
        int        tick;
        int        blk_left;
        logic      blk_level;
        style_left = 0;
        tick       = 0;
        blk_left   = 0;
        blk_level  = 1'b0;
        style      = RX_OPEN;
        forever
        begin
            @(negedge clk);
            if (style_left == 0)
            begin
                style      = rx_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(20, 150);
            end
            style_left--;
            tick++;
            case (style)
                RX_OPEN:
                begin
                    out_ready <= 1'b1;
                end
                RX_THIRD:
                begin
                    out_ready <= (tick % 3 == 0);
                end
                RX_COIN:
                begin
                    out_ready <= 1'($urandom_range(0, 1));
                end
                default:
                begin
                    // alternating blocks of ready and stall
                    if (blk_left == 0)
                    begin
                        blk_level = ~blk_level;
                        blk_left  = blk_level ? $urandom_range(1, 6) : $urandom_range(1, 8);
                    end
                    blk_left--;
                    out_ready <= blk_level;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // result checker and activity count for the watchdog
    // ------------------------------------------------------------------------
    task automatic note_fail(input string msg);
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
            begin
                $display("mismatch: %s", msg);
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_t exp_r;
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end

        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (parser_results.size() == 0)
            begin
                note_fail($sformatf("word %0d unexpected: kind=%0d value=%02h last=%0b dropped=%0b",
                                    result_index, result_kind, value, last, dropped));
            end
            else
            begin
                exp_r = parser_results.pop_front();
                if (result_kind !== exp_r.rkind || value !== exp_r.val ||
                    last !== exp_r.is_last || dropped !== exp_r.lost)
                begin
                    note_fail($sformatf({"word %0d expected kind=%0d value=%02h last=%0b ",
                                         "dropped=%0b, got kind=%0d value=%02h last=%0b ",
                                         "dropped=%0b"},
                                        result_index, exp_r.rkind, exp_r.val, exp_r.is_last,
                                        exp_r.lost, result_kind, value, last, dropped));
                end
            end
            result_index++;
        end
    end

    // watchdog: a hung handshake on either side ends the run
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int        pick;
        bit        big_done;
        stim_row_t row;
        big_done = 1'b0;

        // reset held low from the start, released once
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table; typed rows carry words read straight off the command set
        // chip select high with a returned spi byte of all zeros in the middle
        add_row(1'b0, CHAR_C,    0, '0, '0);
        add_row(1'b0, CHAR_S,    0, '0, '0);
        add_row(1'b1, 8'h00,     2, mk_result(RK_HEX, CHAR_ZERO, 1'b0, 1'b0),
                                    mk_result(RK_HEX, CHAR_ZERO, 1'b1, 1'b0));
        add_row(1'b0, CHAR_ONE,  0, '0, '0);
        add_row(1'b0, CHAR_NL,   1, mk_result(RK_CS, 8'd1, 1'b1, 1'b0), '0);
        // chip select zero spoiled by a bad character where the newline belongs
        add_row(1'b0, CHAR_C,   -1, '0, '0);
        add_row(1'b0, CHAR_S,   -1, '0, '0);
        add_row(1'b0, CHAR_ZERO,-1, '0, '0);
        add_row(1'b0, "X",       0, '0, '0);
        // spi byte of all ones
        add_row(1'b1, 8'hFF,     2, mk_result(RK_HEX, CHAR_F, 1'b0, 1'b0),
                                    mk_result(RK_HEX, CHAR_F, 1'b1, 1'b0));
        // highest mode
        add_row(1'b0, CHAR_M,   -1, '0, '0);
        add_row(1'b0, CHAR_THREE,-1, '0, '0);
        add_row(1'b0, CHAR_NL,   1, mk_result(RK_MODE, 8'd3, 1'b1, 1'b0), '0);
        // bad character right after c, must not start anything
        add_row(1'b0, CHAR_C,   -1, '0, '0);
        add_row(1'b0, "Z",       0, '0, '0);
        // empty data command gives nothing
        add_row(1'b0, CHAR_D,   -1, '0, '0);
        add_row(1'b0, CHAR_NL,   0, '0, '0);
        // data with lowercase digit and a lone last digit closed by two newlines
        add_row(1'b0, CHAR_D,   -1, '0, '0);
        add_row(1'b0, CHAR_F,   -1, '0, '0);
        add_row(1'b0, CHAR_F,   -1, '0, '0);
        add_row(1'b0, "a",      -1, '0, '0);
        add_row(1'b0, "7",      -1, '0, '0);
        add_row(1'b0, CHAR_NINE,-1, '0, '0);
        add_row(1'b0, CHAR_NL,  -1, '0, '0);
        add_row(1'b0, CHAR_NL,  -1, '0, '0);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_word(row.k, row.c, row.n_typed, row.r0, row.r1);
        end

        // sender pauses until the directed words are all out
        drain_outputs();

        // random part: mostly well-formed commands with random content
        work_words = 0;
        while (work_words < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (!big_done && work_words >= 60)
            begin
                // one command that fills the buffer and drops pairs past it
                send_data_cmd($urandom_range(BUFFER_DEPTH + 1, BUFFER_DEPTH + 3), 1'b0);
                big_done = 1'b1;
            end
            else if (pick < 18)
            begin
                flush_parser();
                send_char(CHAR_C);
                send_char(CHAR_S);
                send_char(CHAR_ZERO + 8'($urandom_range(0, 1)));
                send_char(CHAR_NL);
            end
            else if (pick < 34)
            begin
                flush_parser();
                send_char(CHAR_M);
                send_char(CHAR_ZERO + 8'($urandom_range(0, 3)));
                send_char(CHAR_NL);
            end
            else if (pick < 64)
            begin
                send_data_cmd($urandom_range(0, 10), ($urandom_range(0, 4) == 0));
            end
            else if (pick < 76)
            begin
                send_broken_cmd();
            end
            else if (pick < 86)
            begin
                // noise, may also open a command that the next one flushes
                repeat ($urandom_range(1, 4))
                begin
                    send_char(8'($urandom_range(0, 255)));
                end
            end
            else if (pick < 96)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_word(1'b1, 8'($urandom_range(0, 255)), -1, '0, '0);
                end
            end
            else
            begin
                drain_outputs();
            end
        end
        flush_parser();

        // all stimulus in, wait for every owed word, then a little longer
        @(negedge clk);
        in_valid <= 1'b0;
        while (parser_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (parser_results.size() != 0)
        begin
            note_fail($sformatf("%0d words never arrived", parser_results.size()));
        end

        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### serial_to_spi_command_parser_unit.f
+incdir+rtl
rtl/s2spi_pkg.sv
rtl/s2spi_ram.sv
rtl/s2spi_ctrl.sv
rtl/s2spi_dp.sv
rtl/serial_to_spi_command_parser_unit.sv
tb/sv/serial_to_spi_command_parser_unit_tb.sv
